FILE: rtl/tdlfo_pkg.sv
// ----------------------------------------------------------------------------
// tdlfo_pkg
// Shared types and constants of the tick driven multi track lfo bank.
// ----------------------------------------------------------------------------
`default_nettype none

package tdlfo_pkg;

  localparam int TRACKS_DEF    = 8;
  localparam int SINE_BITS_DEF = 10;
  localparam int MAX_RESULTS   = 8;
  localparam int FIFO_DEPTH    = 2;

  localparam logic [6:0] VALUE_MAX    = 7'd127;
  localparam logic [6:0] CENTER_RESET = 7'd64;

  // commands
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;
  localparam logic [1:0] CMD_WRITE = 2'd3;

  // waveform codes
  localparam logic [2:0] WAVE_SINE     = 3'd0;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
  localparam logic [2:0] WAVE_SQUARE   = 3'd2;
  localparam logic [2:0] WAVE_SAW_UP   = 3'd3;
  localparam logic [2:0] WAVE_SAW_DOWN = 3'd4;

  typedef struct packed {
    logic        armed;
    logic [2:0]  waveform;
    logic [15:0] ticks_per_cycle;
    logic [6:0]  center_value;
    logic [6:0]  depth;
    logic [7:0]  cc_number;
    logic [7:0]  channel;
  } settings_t;

  // one queued job for the back end
  typedef struct packed {
    logic        is_write;
    logic [31:0] count;
    logic [2:0]  track;
    settings_t   settings;
  } entry_t;

  typedef struct packed {
    logic [2:0] out_track;
    logic [7:0] out_cc_number;
    logic [7:0] out_channel;
    logic [6:0] out_value;
    logic       last;
  } result_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [16:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/tdlfo_if.sv
// ----------------------------------------------------------------------------
// tdlfo_if
// Command and result channels of the lfo bank.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdlfo_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [2:0]  track;
  logic        armed;
  logic [2:0]  waveform;
  logic [15:0] ticks_per_cycle;
  logic [7:0]  center_value;
  logic [7:0]  depth;
  logic [7:0]  cc_number;
  logic [7:0]  channel;

  modport source (
    output valid, command, track, armed, waveform, ticks_per_cycle,
           center_value, depth, cc_number, channel,
    input  ready
  );
  modport sink (
    input  valid, command, track, armed, waveform, ticks_per_cycle,
           center_value, depth, cc_number, channel,
    output ready
  );
endinterface

interface tdlfo_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] out_track;
  logic [7:0] out_cc_number;
  logic [7:0] out_channel;
  logic [6:0] out_value;
  logic       last;

  modport source (
    output valid, out_track, out_cc_number, out_channel, out_value, last,
    input  ready
  );
  modport sink (
    input  valid, out_track, out_cc_number, out_channel, out_value, last,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/tick_driven_multi_track_lfo_top.sv
// ----------------------------------------------------------------------------
// tick_driven_multi_track_lfo_top
// Bank of tick driven lfos emitting control-change values.
//
// in_ch carries commands: tick, start, stop and track settings writes.
// out_ch carries one item per track whose value changed on a tick, in
// ascending track order, with last set on the final item of that tick.
// Start, stop, writes and ticks while stopped produce no items.
// Commands are taken into a two-entry job queue; start and stop act in the
// front end and are not queued. The back end walks the tracks one at a time
// through a shared divider: an armed track needs one division for its phase
// and a second one for triangle, saw and sine, an unarmed one is skipped.
// Results of a tick hold back by one: each is sent once the next change, or
// the end of the tick, is known. A stalled receiver stops the walk at the
// next change; the queue then fills and in_ch.ready drops.
// Reset stops the bank, clears the count, disarms all tracks (sine, center
// 64, depth 0) and clears the last values.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_driven_multi_track_lfo_top #(
  parameter int TRACKS          = tdlfo_pkg::TRACKS_DEF,
  parameter int SINE_TABLE_BITS = tdlfo_pkg::SINE_BITS_DEF
) (
  input  wire          clk,
  input  wire          rst,
  tdlfo_in_if.sink     in_ch,
  tdlfo_out_if.source  out_ch
);
  import tdlfo_pkg::*;

  logic     push;
  entry_t   push_data;
  logic     full;
  logic     q_valid;
  logic     q_pop;
  entry_t   q_data;
  div_req_t div_req;
  div_rsp_t div_rsp;

  tdlfo_front #(.TRACKS(TRACKS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  tdlfo_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_data)
  );

  tdlfo_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  tdlfo_back #(
    .TRACKS          (TRACKS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

FILE: rtl/tdlfo_front.sv
// ----------------------------------------------------------------------------
// tdlfo_front
// Takes commands, keeps the run flag and tick count, queues ticks and writes.
// ----------------------------------------------------------------------------
`default_nettype none

module tdlfo_front #(
  parameter int TRACKS = tdlfo_pkg::TRACKS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  tdlfo_in_if.sink            in_ch,
  input  wire                 full,
  output logic                push,
  output tdlfo_pkg::entry_t   push_data
);
  import tdlfo_pkg::*;

  logic        running;
  logic [31:0] count;
  logic        accept;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && !full;

  always_comb begin
    push_data.is_write                 = (in_ch.command == CMD_WRITE);
    push_data.count                    = count + 32'd1;
    push_data.track                    = in_ch.track;
    push_data.settings.armed           = in_ch.armed;
    push_data.settings.waveform        = in_ch.waveform;
    push_data.settings.ticks_per_cycle = in_ch.ticks_per_cycle;
    push_data.settings.center_value    = (in_ch.center_value > 8'd127) ? VALUE_MAX :
                                         in_ch.center_value[6:0];
    push_data.settings.depth           = (in_ch.depth > 8'd127) ? VALUE_MAX :
                                         in_ch.depth[6:0];
    push_data.settings.cc_number       = in_ch.cc_number;
    push_data.settings.channel         = in_ch.channel;
    push = 1'b0;
    if (accept) begin
      case (in_ch.command)
        CMD_TICK:  push = running;
        CMD_WRITE: push = (int'(in_ch.track) < TRACKS);
        default:   push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      count   <= '0;
    end else if (accept) begin
      case (in_ch.command)
        CMD_TICK: begin
          if (running) count <= count + 32'd1;
        end
        CMD_START: begin
          count   <= '0;
          running <= 1'b1;
        end
        CMD_STOP:  running <= 1'b0;
        default:   ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tdlfo_fifo.sv
// ----------------------------------------------------------------------------
// tdlfo_fifo
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module tdlfo_fifo (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  tdlfo_pkg::entry_t   push_data,
  output logic                full,
  output logic                pop_valid,
  input  wire                 pop,
  output tdlfo_pkg::entry_t   pop_data
);
  import tdlfo_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);

  entry_t          mem [FIFO_DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [PW:0]     cnt;

  assign full      = (cnt == (PW+1)'(FIFO_DEPTH));
  assign pop_valid = (cnt != '0);
  assign pop_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) wptr <= (wptr == PW'(FIFO_DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == PW'(FIFO_DEPTH - 1)) ? '0 : rptr + 1'b1;
      cnt <= cnt + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tdlfo_div.sv
// ----------------------------------------------------------------------------
// tdlfo_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tdlfo_div (
  input  wire                 clk,
  input  wire                 rst,
  input  tdlfo_pkg::div_req_t req,
  output tdlfo_pkg::div_rsp_t rsp
);
  import tdlfo_pkg::*;

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [31:0] q;
  logic [16:0] rem;
  logic [16:0] dvs;
  logic [17:0] trial;

  assign trial         = {rem, q[31]};
  assign rsp.done      = done;
  assign rsp.quotient  = q;
  assign rsp.remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        q    <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= 17'(trial - {1'b0, dvs});
          q   <= {q[30:0], 1'b1};
        end else begin
          rem <= trial[16:0];
          q   <= {q[30:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tdlfo_back.sv
// ----------------------------------------------------------------------------
// tdlfo_back
// Holds track settings, walks armed tracks per tick and emits changed values.
// ----------------------------------------------------------------------------
`default_nettype none

module tdlfo_back #(
  parameter int TRACKS          = tdlfo_pkg::TRACKS_DEF,
  parameter int SINE_TABLE_BITS = tdlfo_pkg::SINE_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 q_valid,
  input  tdlfo_pkg::entry_t   q_data,
  output logic                q_pop,
  output tdlfo_pkg::div_req_t div_req,
  input  tdlfo_pkg::div_rsp_t div_rsp,
  tdlfo_out_if.source         out_ch
);
  import tdlfo_pkg::*;

  localparam int IW        = $clog2(TRACKS + 1);
  localparam int TW        = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int SINE_SIZE = 1 << SINE_TABLE_BITS;
  localparam int QUARTER   = SINE_SIZE / 4;

  typedef logic signed [15:0] sine_rom_t [SINE_SIZE];

  // quarter-wave odd polynomial in q30, rounded to q15 and mirrored
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] v;
    logic [63:0] s;
    int          quad;
    int          r;
    int          pos;
    for (int k = 0; k < SINE_SIZE; k++) begin
      quad = k / QUARTER;
      r    = k % QUARTER;
      pos  = (quad % 2 == 1) ? (QUARTER - r) : r;
      x    = (64'(pos) << 30) / QUARTER;
      x2   = (x * x) >> 30;
      t    = 64'd5026995 - ((x2 * 64'd172271) >> 30);
      t    = 64'd85569306 - ((x2 * t) >> 30);
      t    = 64'd693598668 - ((x2 * t) >> 30);
      t    = 64'd1686629713 - ((x2 * t) >> 30);
      v    = (((x * t) >> 30) + 64'd16384) >> 15;
      s    = (v > 64'd32767) ? 64'd32767 : v;
      rom[k] = (quad >= 2) ? -$signed(s[15:0]) : $signed(s[15:0]);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_SCAN   = 12'b000000000010,
    S_MOD    = 12'b000000000100,
    S_SHAPE  = 12'b000000001000,
    S_SINDIV = 12'b000000010000,
    S_ROM    = 12'b000000100000,
    S_SMUL   = 12'b000001000000,
    S_SRND   = 12'b000010000000,
    S_RMUL   = 12'b000100000000,
    S_RDIV   = 12'b001000000000,
    S_FIN    = 12'b010000000000,
    S_FLUSH  = 12'b100000000000
  } state_t;

  state_t          state;
  settings_t       trk      [TRACKS];
  logic [6:0]      last_out [TRACKS];
  logic [31:0]     count_r;
  logic [IW-1:0]   idx;
  logic [3:0]      nres;
  logic [15:0]     p_r;
  logic            sign_r;
  logic [16:0]     mag_r;
  logic signed [7:0]  w_r;
  logic [SINE_TABLE_BITS-1:0] rom_addr;
  logic signed [15:0] rom_q;
  logic signed [23:0] prod_r;
  logic            pend_valid;
  result_t         pend;
  logic            o_valid;
  result_t         o_data;

  settings_t          cur;
  logic [15:0]        tval;
  logic               out_free;
  logic               send;
  logic signed [19:0] a4;
  logic [19:0]        a4_abs;
  logic signed [19:0] xs;
  logic [19:0]        xs_abs;
  logic [23:0]        rprod;
  logic [23:0]        sabs;
  logic [23:0]        sq;
  logic signed [8:0]  sum;
  logic [6:0]         v;
  logic [6:0]         qd;

  assign cur      = trk[idx[TW-1:0]];
  assign tval     = (cur.ticks_per_cycle == 16'd0) ? 16'd1 : cur.ticks_per_cycle;
  assign out_free = !o_valid || out_ch.ready;
  // a held item moves to the output register this cycle
  assign send     = pend_valid && out_free &&
                    (((state == S_FIN) && (v != last_out[idx[TW-1:0]])) ||
                     (state == S_FLUSH));

  assign out_ch.valid         = o_valid;
  assign out_ch.out_track     = o_data.out_track;
  assign out_ch.out_cc_number = o_data.out_cc_number;
  assign out_ch.out_channel   = o_data.out_channel;
  assign out_ch.out_value     = o_data.out_value;
  assign out_ch.last          = o_data.last;

  assign q_pop = (state == S_IDLE) && q_valid;

  always_comb begin
    a4     = $signed({2'b0, p_r, 2'b0}) - $signed({3'b0, tval, 1'b0});
    a4_abs = a4[19] ? 20'(-a4) : a4;
    case (cur.waveform)
      WAVE_TRIANGLE: xs = $signed({4'b0, tval}) - $signed(a4_abs);
      WAVE_SAW_UP:   xs = $signed({3'b0, p_r, 1'b0}) - $signed({4'b0, tval});
      default:       xs = $signed({4'b0, tval}) - $signed({3'b0, p_r, 1'b0});
    endcase
    xs_abs = xs[19] ? 20'(-xs) : xs;
    rprod  = 24'(cur.depth * mag_r);
    sabs   = prod_r[23] ? 24'(-prod_r) : prod_r;
    sq     = (sabs + 24'd16384) >> 15;
    sum    = $signed({2'b0, cur.center_value}) + 9'(w_r);
    if (sum < 0) begin
      v = 7'd0;
    end else if (sum > $signed({2'b0, VALUE_MAX})) begin
      v = VALUE_MAX;
    end else begin
      v = sum[6:0];
    end
    qd = div_rsp.quotient[6:0];
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = count_r;
    div_req.divisor  = {1'b0, tval};
    case (state)
      S_SCAN: begin
        div_req.start = (idx != IW'(TRACKS)) && (nres != 4'(MAX_RESULTS)) && cur.armed;
      end
      S_SHAPE: begin
        div_req.start    = (cur.waveform == WAVE_SINE);
        div_req.dividend = {p_r, 16'h0};
      end
      S_RMUL: begin
        div_req.start    = 1'b1;
        div_req.dividend = 32'({rprod, 1'b0}) + 32'(tval);
        div_req.divisor  = {tval, 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rom_q <= SINE_ROM[rom_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      o_valid    <= 1'b0;
      idx        <= '0;
      nres       <= '0;
      for (int i = 0; i < TRACKS; i++) begin
        trk[i]      <= '{armed: 1'b0, waveform: WAVE_SINE, ticks_per_cycle: 16'd0,
                         center_value: CENTER_RESET, depth: 7'd0, cc_number: 8'd0,
                         channel: 8'd0};
        last_out[i] <= 7'd0;
      end
    end else begin
      if (out_ch.ready && !send) o_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_data.is_write) begin
              trk[TW'(q_data.track)] <= q_data.settings;
            end else begin
              count_r <= q_data.count;
              idx     <= '0;
              nres    <= '0;
              state   <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (idx == IW'(TRACKS) || nres == 4'(MAX_RESULTS)) begin
            state <= S_FLUSH;
          end else if (!cur.armed) begin
            idx <= idx + 1'b1;
          end else begin
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (div_rsp.done) begin
            p_r   <= div_rsp.remainder[15:0];
            state <= S_SHAPE;
          end
        end
        S_SHAPE: begin
          case (cur.waveform)
            WAVE_SINE: state <= S_SINDIV;
            WAVE_TRIANGLE, WAVE_SAW_UP, WAVE_SAW_DOWN: begin
              sign_r <= xs[19];
              mag_r  <= xs_abs[16:0];
              state  <= S_RMUL;
            end
            WAVE_SQUARE: begin
              w_r   <= ({p_r, 1'b0} < {1'b0, tval}) ? $signed({1'b0, cur.depth}) :
                       -$signed({1'b0, cur.depth});
              state <= S_FIN;
            end
            default: begin
              w_r   <= 8'sd0;
              state <= S_FIN;
            end
          endcase
        end
        S_SINDIV: begin
          if (div_rsp.done) begin
            rom_addr <= div_rsp.quotient[15 -: SINE_TABLE_BITS];
            state    <= S_ROM;
          end
        end
        S_ROM:  state <= S_SMUL;
        S_SMUL: begin
          prod_r <= rom_q * $signed({1'b0, cur.depth});
          state  <= S_SRND;
        end
        S_SRND: begin
          w_r   <= prod_r[23] ? -$signed({1'b0, sq[6:0]}) : $signed({1'b0, sq[6:0]});
          state <= S_FIN;
        end
        S_RMUL: state <= S_RDIV;
        S_RDIV: begin
          if (div_rsp.done) begin
            w_r   <= sign_r ? -$signed({1'b0, qd}) : $signed({1'b0, qd});
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (v == last_out[idx[TW-1:0]]) begin
            idx   <= idx + 1'b1;
            state <= S_SCAN;
          end else if (!pend_valid || out_free) begin
            // the held result is not the last one, pass it on
            if (pend_valid) begin
              o_valid <= 1'b1;
              o_data  <= '{out_track: pend.out_track, out_cc_number: pend.out_cc_number,
                           out_channel: pend.out_channel, out_value: pend.out_value,
                           last: 1'b0};
            end
            pend.out_track          <= 3'(idx);
            pend.out_cc_number      <= cur.cc_number;
            pend.out_channel        <= cur.channel;
            pend.out_value          <= v;
            pend.last               <= 1'b1;
            pend_valid              <= 1'b1;
            last_out[idx[TW-1:0]]   <= v;
            nres                    <= nres + 4'd1;
            idx                     <= idx + 1'b1;
            state                   <= S_SCAN;
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            o_valid    <= 1'b1;
            o_data     <= pend;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sim/tb_tick_driven_multi_track_lfo_top.sv
// ----------------------------------------------------------------------------
// tb_tick_driven_multi_track_lfo_top
// Drives tick, start, stop and track writes into the lfo bank under random
// idling on both channels, predicts the control-change items of every tick
// and checks each one field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tick_driven_multi_track_lfo_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tdlfo_pkg::*;

  localparam int NTRK = 8;
  localparam int SBITS = 10;
  localparam int SSIZE = 1 << SBITS;

  logic clk;
  logic rst;
  bit   failed;
  bit   calm;

  tdlfo_in_if  in_ch();
  tdlfo_out_if out_ch();

  tick_driven_multi_track_lfo_top DUT (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // predictor state
  logic [31:0] lfo_count;
  bit          lfo_running;
  settings_t   lfo_trk [NTRK];
  logic [6:0]  lfo_prev [NTRK];
  int          sine_q15 [SSIZE];
  result_t     cc_pending [$];

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #80ms;
    $display("[tick_driven_multi_track_lfo_top] ERROR");
    $finish;
  end

  function automatic longint unsigned quarter_wave(longint unsigned x);
    longint unsigned x2, t;
    x2 = (x * x) >> 30;
    t = 64'd5026995 - ((x2 * 64'd172271) >> 30);
    t = 64'd85569306 - ((x2 * t) >> 30);
    t = 64'd693598668 - ((x2 * t) >> 30);
    t = 64'd1686629713 - ((x2 * t) >> 30);
    return (x * t) >> 30;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint a, q;
    a = num < 0 ? -num : num;
    q = (2 * a + den) / (2 * den);
    return num < 0 ? -q : q;
  endfunction

  function automatic logic [6:0] lfo_value(settings_t s);
    longint tp, p, d, w, o, a;
    int unsigned f;
    tp = s.ticks_per_cycle == 0 ? 1 : s.ticks_per_cycle;
    p = lfo_count % tp;
    d = s.depth;
    case (s.waveform)
      WAVE_SINE: begin
        f = (p << 16) / tp;
        w = round_div(sine_q15[(f >> (16 - SBITS)) & (SSIZE - 1)] * d, 32768);
      end
      WAVE_TRIANGLE: begin
        a = 4 * p - 2 * tp;
        if (a < 0) a = -a;
        w = round_div(d * (tp - a), tp);
      end
      WAVE_SQUARE: w = (2 * p < tp) ? d : -d;
      WAVE_SAW_UP: w = round_div(d * (2 * p - tp), tp);
      WAVE_SAW_DOWN: w = round_div(d * (tp - 2 * p), tp);
      default: w = 0;
    endcase
    o = s.center_value + w;
    if (o < 0) o = 0;
    if (o > 127) o = 127;
    return o[6:0];
  endfunction

  task automatic predict_cc(logic [1:0] cmd, logic [2:0] trk, settings_t s);
    result_t r;
    logic [6:0] v;
    int n;
    n = 0;
    case (cmd)
      CMD_START: begin
        lfo_count = 0;
        lfo_running = 1;
      end
      CMD_STOP: lfo_running = 0;
      CMD_WRITE: lfo_trk[trk] = s;
      default: if (lfo_running) begin
        lfo_count++;
        for (int i = 0; i < NTRK; i++) begin
          if (lfo_trk[i].armed) begin
            v = lfo_value(lfo_trk[i]);
            if (v != lfo_prev[i]) begin
              lfo_prev[i] = v;
              r.out_track = i;
              r.out_cc_number = lfo_trk[i].cc_number;
              r.out_channel = lfo_trk[i].channel;
              r.out_value = v;
              r.last = 0;
              cc_pending.push_back(r);
              n++;
            end
          end
        end
        if (n > 0) cc_pending[$].last = 1;
      end
    endcase
  endtask

  task automatic send_cmd(logic [1:0] cmd, logic [2:0] trk, bit arm, logic [2:0] wave,
                          logic [15:0] tpc, logic [7:0] ctr, logic [7:0] dep,
                          logic [7:0] cc, logic [7:0] ch);
    settings_t s;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.command <= cmd;
    in_ch.track <= trk;
    in_ch.armed <= arm;
    in_ch.waveform <= wave;
    in_ch.ticks_per_cycle <= tpc;
    in_ch.center_value <= ctr;
    in_ch.depth <= dep;
    in_ch.cc_number <= cc;
    in_ch.channel <= ch;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    s = '{arm, wave, tpc, ctr > 127 ? 7'd127 : ctr[6:0],
          dep > 127 ? 7'd127 : dep[6:0], cc, ch};
    predict_cc(cmd, trk, s);
  endtask

  task automatic write_random(logic [2:0] trk, bit short_period);
    logic [15:0] tpc;
    tpc = short_period ? $urandom_range(0, 40) : $urandom;
    send_cmd(CMD_WRITE, trk, $urandom_range(0, 3) != 0, $urandom, tpc, $urandom,
             $urandom, $urandom, $urandom);
  endtask

  task automatic tick_n(int n);
    repeat (n) send_cmd(CMD_TICK, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic test_directed();
    // extremes, all waves including unknown codes, clamping, period zero
    send_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(CMD_WRITE, 0, 1, WAVE_SINE, 16'd0, 8'd255, 8'd255, 8'hff, 8'hff);
    send_cmd(CMD_WRITE, 1, 1, WAVE_TRIANGLE, 16'd8, 8'd64, 8'd127, 8'd1, 8'd2);
    send_cmd(CMD_WRITE, 2, 1, WAVE_SQUARE, 16'd4, 8'd0, 8'd200, 8'd3, 8'd4);
    send_cmd(CMD_WRITE, 3, 1, WAVE_SAW_UP, 16'd5, 8'd64, 8'd64, 8'd5, 8'd6);
    send_cmd(CMD_WRITE, 4, 1, WAVE_SAW_DOWN, 16'hffff, 8'd127, 8'd127, 8'd7, 8'd8);
    send_cmd(CMD_WRITE, 5, 1, 3'd5, 16'd3, 8'd200, 8'd50, 8'd9, 8'd10);
    send_cmd(CMD_WRITE, 6, 1, 3'd7, 16'd3, 8'd10, 8'd0, 8'd11, 8'd12);
    send_cmd(CMD_WRITE, 7, 1, WAVE_SINE, 16'd16, 8'd64, 8'd127, 8'd0, 8'd0);
    send_cmd(CMD_START, 0, 0, 0, 0, 0, 0, 0, 0);
    tick_n(6);
    send_cmd(CMD_STOP, 7, 1, 7, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff);
    tick_n(2);
    send_cmd(CMD_START, 0, 0, 0, 0, 0, 0, 0, 0);
    tick_n(3);
  endtask

  task automatic test_random(int n);
    int c;
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, 19);
      if (c < 3) write_random($urandom, $urandom_range(0, 7) != 0);
      else if (c == 3) send_cmd(CMD_START, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom);
      else if (c == 4) send_cmd(CMD_STOP, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom);
      else tick_n(1);
    end
  endtask

  // result checker with random stalls
  initial begin
    result_t got, want;
    out_ch.ready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.out_track, out_ch.out_cc_number, out_ch.out_channel,
                out_ch.out_value, out_ch.last};
        if (cc_pending.size() == 0) begin
          $display("%0t: unexpected item %p", $time, got);
          failed = 1;
        end else begin
          want = cc_pending.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            failed = 1;
          end
        end
      end
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_ch.ready <= 1;
    end
  end

  initial begin
    int waitc;
    rst = 1;
    in_ch.valid = 0;
    in_ch.command = CMD_TICK;
    in_ch.track = 0;
    in_ch.armed = 0;
    in_ch.waveform = 0;
    in_ch.ticks_per_cycle = 0;
    in_ch.center_value = 0;
    in_ch.depth = 0;
    in_ch.cc_number = 0;
    in_ch.channel = 0;
    lfo_count = 0;
    lfo_running = 0;
    for (int i = 0; i < NTRK; i++) begin
      lfo_trk[i] = '{0, WAVE_SINE, 16'd0, CENTER_RESET, 7'd0, 8'd0, 8'd0};
      lfo_prev[i] = 0;
    end
    for (int k = 0; k < SSIZE; k++) begin
      int unsigned q, quad, r, pos;
      longint unsigned v;
      q = SSIZE / 4;
      quad = k / q;
      r = k % q;
      pos = quad[0] ? q - r : r;
      v = (quarter_wave((longint'(pos) << 30) / q) + (1 << 14)) >> 15;
      sine_q15[k] = v > 32767 ? 32767 : int'(v);
      if (quad >= 2) sine_q15[k] = -sine_q15[k];
    end
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random(320);
    calm = 1;
    test_random(60);
    in_ch.valid <= 0;
    waitc = 0;
    while (cc_pending.size() != 0 && waitc < 200000) begin
      @(posedge clk);
      waitc++;
    end
    repeat (700) @(posedge clk);
    if (!failed && cc_pending.size() == 0) begin
      $display("[tick_driven_multi_track_lfo_top] OK");
    end else begin
      $display("[tick_driven_multi_track_lfo_top] ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire
